/* rtl/olab_pkg.sv */
package olab_pkg;

	// angle and register widths
	localparam int ANGLE_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;

	// product of blend count and arc magnitude, and the divider step counter width
	localparam int PROD_W    = CFG_W + ANGLE_BITS;
	localparam int DIV_CNT_W = $clog2(PROD_W);

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS_NEEDED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_OPEN_LOOP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_LENGTH       = 3'd3;

	// register reset values
	localparam logic [CFG_W-1:0] LOCK_THRESHOLD_RST    = 16'd8866;
	localparam logic [CFG_W-1:0] HOLD_TICKS_NEEDED_RST = 16'd100;
	localparam logic [CFG_W-1:0] MIN_OPEN_LOOP_RST     = 16'd20000;
	localparam logic [CFG_W-1:0] RAMP_LENGTH_RST       = 16'd500;

	typedef logic [ANGLE_BITS-1:0] angle_t;

	typedef enum logic [1:0] {
		MODE_OPEN     = 2'd0,
		MODE_CONVERGE = 2'd1,
		MODE_BLEND    = 2'd2,
		MODE_OBSERVER = 2'd3
	} blend_mode_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_ARC,
		SEQ_STEP,
		SEQ_DIV,
		SEQ_DONE
	} seq_state_t;

	typedef struct packed {
		angle_t           open_loop_angle;
		angle_t           observer_angle;
		logic [CFG_W-1:0] open_loop_count;
	} sample_t;

	typedef struct packed {
		angle_t      final_angle;
		blend_mode_t mode;
	} result_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/open_loop_observer_angle_blend_top.sv */
// Open-loop to observer rotor angle handover. Each sample carries the forced
// open-loop angle, the observer angle and the open-loop tick count; each gives
// exactly one result with the chosen angle and the mode that produced it.
// Angles are 16-bit binary angles, 65536 is one turn. The mode goes open loop,
// converging (waits for |shortest-arc difference| < lock_threshold on
// hold_ticks_needed consecutive samples), blending (open-loop angle plus
// blend_count*diff/ramp_length, truncated toward zero) and observer only.
// Timing: one sample at a time. A sample outside the ramp passes the arc, step
// and done states before its result shows, and the input is freed when that
// result enters the output register; a ramp sample also waits in the divide
// state on the radix-2 divider, which needs one cycle per bit of the 32-bit
// product. A finished result sits in the output register, so the next sample
// is accepted while it waits.
// Configuration writes are always ready and are meant for idle periods.
module open_loop_observer_angle_blend_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  olab_pkg::sample_t                 sample,
	output logic                              result_valid,
	input  logic                              result_stall,
	output olab_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [olab_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [olab_pkg::CFG_W-1:0]        cfg_data
);

	localparam int AB = olab_pkg::ANGLE_BITS;
	localparam int PW = olab_pkg::PROD_W;
	localparam int CW = olab_pkg::CFG_W;

	olab_pkg::seq_state_t  state_q, state_d;
	olab_pkg::blend_mode_t mode_q, mode_d;
	logic [CW-1:0]         hold_cnt_q, hold_cnt_d;
	logic [CW-1:0]         blend_cnt_q, blend_cnt_d;

	logic [CW-1:0] lock_thr_q, hold_need_q, min_ol_q, ramp_len_q;

	olab_pkg::angle_t      ol_q, ob_q;
	logic [CW-1:0]         cnt_in_q;
	olab_pkg::angle_t      d_q, mag_q;
	olab_pkg::angle_t      res_q, res_d;
	olab_pkg::blend_mode_t res_mode_q;
	olab_pkg::result_t     out_q;
	logic                  out_valid_q;

	logic                  res_load;
	logic                  out_load;
	logic                  div_start;
	logic [CW-1:0]         hold_inc;
	logic [CW-1:0]         blend_inc;
	logic [PW-1:0]         prod;
	olab_pkg::angle_t      d_arc;
	olab_pkg::angle_t      q_mag;
	olab_pkg::angle_t      offset;
	olab_pkg::div_stat_t   div_stat;
	logic [PW-1:0]         div_quo;

	logic sample_acc;

	assign sample_stall = state_q != olab_pkg::SEQ_IDLE;
	assign sample_acc   = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_thr_q  <= olab_pkg::LOCK_THRESHOLD_RST;
			hold_need_q <= olab_pkg::HOLD_TICKS_NEEDED_RST;
			min_ol_q    <= olab_pkg::MIN_OPEN_LOOP_RST;
			ramp_len_q  <= olab_pkg::RAMP_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				olab_pkg::REG_LOCK_THRESHOLD:    lock_thr_q  <= cfg_data;
				olab_pkg::REG_HOLD_TICKS_NEEDED: hold_need_q <= cfg_data;
				olab_pkg::REG_MIN_OPEN_LOOP:     min_ol_q    <= cfg_data;
				olab_pkg::REG_RAMP_LENGTH:       ramp_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// wrapped difference; as two's complement it already lies in [-half, half)
	assign d_arc = sample.observer_angle - sample.open_loop_angle;

	// ramp arithmetic
	assign hold_inc  = hold_cnt_q + 1'b1;
	assign blend_inc = blend_cnt_q + 1'b1;
	assign prod      = PW'(blend_inc) * PW'(mag_q);
	assign q_mag     = div_quo[AB-1:0];
	assign offset    = d_q[AB-1] ? -q_mag : q_mag;

	olab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (ramp_len_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// sequencer next state and mode update
	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		hold_cnt_d  = hold_cnt_q;
		blend_cnt_d = blend_cnt_q;
		res_d       = ol_q;
		res_load    = 1'b0;
		div_start   = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			olab_pkg::SEQ_IDLE: begin
				if (sample_acc) begin
					state_d = olab_pkg::SEQ_ARC;
				end
			end
			olab_pkg::SEQ_ARC: begin
				state_d = olab_pkg::SEQ_STEP;
			end
			olab_pkg::SEQ_STEP: begin
				state_d  = olab_pkg::SEQ_DONE;
				res_load = 1'b1;
				unique case (mode_q)
					olab_pkg::MODE_OPEN: begin
						if (cnt_in_q >= min_ol_q) begin
							mode_d = olab_pkg::MODE_CONVERGE;
						end
					end
					olab_pkg::MODE_CONVERGE: begin
						if (mag_q < lock_thr_q) begin
							if (hold_inc >= hold_need_q) begin
								hold_cnt_d = '0;
								mode_d     = olab_pkg::MODE_BLEND;
							end else begin
								hold_cnt_d = hold_inc;
							end
						end else begin
							hold_cnt_d = '0;
						end
					end
					olab_pkg::MODE_BLEND: begin
						if (blend_inc >= ramp_len_q) begin
							blend_cnt_d = ramp_len_q;
							mode_d      = olab_pkg::MODE_OBSERVER;
							res_d       = ol_q + d_q;
						end else begin
							blend_cnt_d = blend_inc;
							res_load    = 1'b0;
							div_start   = 1'b1;
							state_d     = olab_pkg::SEQ_DIV;
						end
					end
					olab_pkg::MODE_OBSERVER: begin
						res_d = ob_q;
					end
					default: ;
				endcase
			end
			olab_pkg::SEQ_DIV: begin
				res_d = ol_q + offset;
				if (div_stat.done) begin
					res_load = 1'b1;
					state_d  = olab_pkg::SEQ_DONE;
				end
			end
			olab_pkg::SEQ_DONE: begin
				if (!out_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = olab_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = olab_pkg::SEQ_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olab_pkg::SEQ_IDLE;
			mode_q      <= olab_pkg::MODE_OPEN;
			hold_cnt_q  <= '0;
			blend_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			hold_cnt_q  <= hold_cnt_d;
			blend_cnt_q <= blend_cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			ol_q     <= sample.open_loop_angle;
			ob_q     <= sample.observer_angle;
			cnt_in_q <= sample.open_loop_count;
			d_q      <= d_arc;
			mag_q    <= d_arc[AB-1] ? -d_arc : d_arc;
		end
		if (res_load) begin
			res_q      <= res_d;
			res_mode_q <= mode_q;
		end
		if (out_load) begin
			out_q.final_angle <= res_q;
			out_q.mode        <= res_mode_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// the divider is only started for a ramp sample
	a_div_in_blend: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> mode_q == olab_pkg::MODE_BLEND)
		else $error("divider started outside the ramp");

	// the divider is running or finishing while the sequencer waits on it
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == olab_pkg::SEQ_DIV |-> div_stat.busy || div_stat.done)
		else $error("sequencer waits on an idle divider");

	// the mode only moves one step forward
	a_mode_forward: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != $past(mode_q) |->
			mode_q == olab_pkg::blend_mode_t'($past(mode_q) + 2'd1))
		else $error("mode skipped or went back");

	// the hold counter is idle outside convergence
	a_hold_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != olab_pkg::MODE_CONVERGE |-> hold_cnt_q == '0)
		else $error("hold count left over");

	// a new result comes only from the finishing state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q == olab_pkg::SEQ_DONE && !sample_acc)
		else $error("result loaded out of sequence");

endmodule

/* rtl/olab_div.sv */
module olab_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [olab_pkg::PROD_W-1:0]  dividend,
	input  logic [olab_pkg::CFG_W-1:0]   divisor,
	output olab_pkg::div_stat_t          stat,
	output logic [olab_pkg::PROD_W-1:0]  quotient
);

	localparam int PW = olab_pkg::PROD_W;
	localparam int DW = olab_pkg::CFG_W;
	localparam int CW = olab_pkg::DIV_CNT_W;
	localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

	logic [DW-1:0] rem_q;
	logic [PW-1:0] quo_q;
	logic [DW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0] rem_sh;
	logic [DW:0] rem_sub;
	logic        fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh  = {rem_q, quo_q[PW-1]};
		fits    = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[PW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	// a remainder never reaches the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < dsr_q || dsr_q == '0)
		else $error("divider remainder out of range");

	// done follows the last step only
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("divider done without a run");

endmodule
